@@ rtl/core/s2cd_pkg.sv @@
package s2cd_pkg;

  // Fixed formats
  localparam int WORK_BITS = 30;   // Q2.30 rotation vectors
  localparam int XW        = 33;   // rotation vector width
  localparam int ZW        = 34;   // residual angle width, Q30 radians
  localparam int AMW       = 14;   // angle magnitude width, 1/128 degree
  localparam int OW        = 25;   // coordinate width, signed Q8.16
  localparam int ANG_SHIFT = 25;   // Q55 product down to Q30

  // Angle constants in 1/128 degree
  localparam logic [15:0]        DEG128_FULL    = 16'd46080;
  localparam logic [15:0]        DEG128_QUARTER = 16'd11520;
  localparam logic [15:0]        DEG128_HALF    = 16'd23040;
  localparam logic [15:0]        DEG128_3Q      = 16'd34560;
  localparam logic signed [14:0] EL_MAX         = 15'sd11520;
  localparam logic signed [14:0] EL_MIN         = -15'sd11520;

  // pi/180 in Q48, atan(1) in Q30
  localparam logic [42:0] RAD_PER_DEG_Q48 = 43'd4912665105575;
  localparam logic [63:0] QUARTER_PI_Q30  = 64'd843314857;

  // 1.0 in unsigned Q8.16, used for a zero length
  localparam logic [23:0] RADIUS_ONE = 24'h010000;

  // Coordinate limits
  localparam logic signed [OW-1:0] OUT_MAX = 25'h0FFFFFF;
  localparam logic signed [OW-1:0] OUT_MIN = 25'h1000000;

  typedef enum logic [1:0] {QUAD_I, QUAD_II, QUAD_III, QUAD_IV} quad_t;

  // Restoring division, elaboration only
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [64:0] r;
    int          b;
    q = '0;
    r = '0;
    for (b = 63; b >= 0; b--) begin
      r = {r[63:0], n[b]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Bitwise integer square root, elaboration only
  function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
    logic [63:0] n;
    logic [63:0] res;
    logic [63:0] bt;
    int          j;
    n   = n_in;
    res = '0;
    bt  = 64'd1 << 62;
    for (j = 0; j < 32; j++) begin
      if (bt > n) bt = bt >> 2;
    end
    for (j = 0; j < 32; j++) begin
      if (bt != '0) begin
        if (n >= res + bt) begin
          n   = n - (res + bt);
          res = (res >> 1) + bt;
        end else begin
          res = res >> 1;
        end
        bt = bt >> 2;
      end
    end
    return res;
  endfunction

  // atan(2^-i) in Q30: alternating series in Q62, truncated terms, rounded
  function automatic logic [63:0] atan_q30(input int i);
    logic signed [63:0] sum;
    logic [63:0]        term;
    logic [63:0]        u;
    int                 k;
    int                 e;
    sum = '0;
    if (i == 0) return QUARTER_PI_Q30;
    for (k = 0; k < 32; k++) begin
      e = i * (2 * k + 1);
      if (e <= 62) begin
        term = udiv64(64'd1 << (62 - e), 64'(2 * k + 1));
        if (k[0]) sum = sum - $signed(term);
        else      sum = sum + $signed(term);
      end
    end
    u = 64'(sum) + (64'd1 << 31);
    return u >> 32;
  endfunction

  // Inverse CORDIC gain in Q30 for a given number of steps
  function automatic logic [63:0] inv_gain_q30(input int steps);
    logic [63:0] p;
    logic [63:0] add;
    int          i;
    p = 64'd1 << WORK_BITS;
    for (i = 0; i < steps; i++) begin
      add = (2 * i <= WORK_BITS) ? (64'd1 << (WORK_BITS - 2 * i)) : 64'd0;
      p   = (p * ((64'd1 << WORK_BITS) + add) + (64'd1 << (WORK_BITS - 1))) >> WORK_BITS;
    end
    return isqrt64(udiv64(64'd1 << 62, p) << 28);
  endfunction

endpackage

@@ rtl/core/spherical_to_cartesian_degrees_core.sv @@
// Channel | Direction | Handshake            | Payload
// in_     | input     | in_valid / in_stall  | azimuth u16, elevation s15, radius u24 Q8.16
// out_    | output    | out_valid / out_stall| x_coord, y_coord, z_coord s25 Q8.16
//
// One request per cycle while not stalled; the stages run A, B, the chain of
// CORDIC rotation stages (one stage per rotation step), then R, M1 and M2.
// Synchronous active-low rst_n clears the stage valid bits only.
// A stage moves when it is empty or its successor moves, so bubbles close up;
// in_stall rises only when every stage holds a request and out_stall is high.
module spherical_to_cartesian_degrees_core #(
  parameter int ROTATION_STEPS = 16,
  parameter int FRACTION_BITS  = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [15:0]         in_azimuth,
  input  logic signed [14:0]  in_elevation,
  input  logic [23:0]         in_radius,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [24:0]  out_x_coord,
  output logic signed [24:0]  out_y_coord,
  output logic signed [24:0]  out_z_coord
);
  import s2cd_pkg::*;

  localparam int N     = ROTATION_STEPS;
  localparam int F     = FRACTION_BITS;
  localparam int L     = N + 5;            // total stages
  localparam int CW    = F + 2;            // sin/cos width
  localparam int TW    = 26;               // radius*cos(el) width
  localparam int RW    = TW + CW;          // product width
  localparam int SHIFT = WORK_BITS - F;
  localparam int APW   = AMW + 43;         // angle product width

  localparam logic signed [XW-1:0] GAIN      = XW'(inv_gain_q30(N));
  localparam logic signed [XW-1:0] ONE_Q30   = XW'(64'd1 << WORK_BITS);
  localparam logic [XW-1:0]        UNIT_HALF = XW'(64'd1 << (SHIFT - 1));
  localparam logic [RW-1:0]        PROD_HALF = RW'(64'd1 << (F - 1));
  localparam logic signed [CW-1:0] UNIT     = CW'(64'd1 << F);

  // Clamp to [-1,1] in Q30, round to F fraction bits, halves away from zero
  function automatic logic signed [CW-1:0] to_unit(input logic signed [XW-1:0] v);
    logic signed [XW-1:0] c;
    logic [XW-1:0]        m;
    if (v > ONE_Q30)       c = ONE_Q30;
    else if (v < -ONE_Q30) c = -ONE_Q30;
    else                   c = v;
    m = c[XW-1] ? XW'(-c) : XW'(c);
    m = (m + UNIT_HALF) >> SHIFT;
    return c[XW-1] ? CW'(-m) : CW'(m);
  endfunction

  // Drop F fraction bits, halves away from zero
  function automatic logic signed [RW-1:0] rnd_prod(input logic signed [RW-1:0] v);
    logic [RW-1:0] m;
    m = v[RW-1] ? RW'(-v) : RW'(v);
    m = (m + PROD_HALF) >> F;
    return v[RW-1] ? -m : m;
  endfunction

  function automatic logic signed [OW-1:0] sat_out(input logic signed [RW-1:0] v);
    if (v > RW'(OUT_MAX)) return OUT_MAX;
    if (v < RW'(OUT_MIN)) return OUT_MIN;
    return v[OW-1:0];
  endfunction

  // Stage valid bits and advance chain
  logic [L-1:0] v_r;
  wire  [L:0]   adv;

  assign adv[L] = !out_stall;
  for (genvar j = 0; j < L; j++) begin : g_adv
    assign adv[j] = !v_r[j] || adv[j+1];
  end

  assign in_stall  = !adv[0];
  assign out_valid = v_r[L-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) v_r[0] <= in_valid;
      for (int j = 1; j < L; j++) begin
        if (adv[j]) v_r[j] <= v_r[j-1];
      end
    end
  end

  // Stage A: azimuth wrap and quadrant split, elevation clamp, zero length
  logic [15:0]        az_wrap;
  logic [15:0]        az_red;
  logic signed [14:0] el_sat;
  logic signed [14:0] el_abs;
  quad_t              a_q_nxt, a_q_r;
  logic [AMW-1:0]     a_az_nxt, a_az_r;
  logic [AMW-1:0]     a_el_nxt, a_el_r;
  logic               a_elneg_nxt, a_elneg_r;
  logic [23:0]        a_rad_nxt, a_rad_r;

  always_comb begin
    az_wrap = (in_azimuth >= DEG128_FULL) ? in_azimuth - DEG128_FULL : in_azimuth;
    priority if (az_wrap < DEG128_QUARTER) begin
      a_q_nxt = QUAD_I;
      az_red  = az_wrap;
    end else if (az_wrap < DEG128_HALF) begin
      a_q_nxt = QUAD_II;
      az_red  = az_wrap - DEG128_QUARTER;
    end else if (az_wrap < DEG128_3Q) begin
      a_q_nxt = QUAD_III;
      az_red  = az_wrap - DEG128_HALF;
    end else begin
      a_q_nxt = QUAD_IV;
      az_red  = az_wrap - DEG128_3Q;
    end
    a_az_nxt = az_red[AMW-1:0];

    priority if (in_elevation > EL_MAX) el_sat = EL_MAX;
    else if (in_elevation < EL_MIN)     el_sat = EL_MIN;
    else                                el_sat = in_elevation;
    a_elneg_nxt = el_sat[14];
    el_abs      = el_sat[14] ? -el_sat : el_sat;
    a_el_nxt    = el_abs[AMW-1:0];

    a_rad_nxt = (in_radius == '0) ? RADIUS_ONE : in_radius;
  end

  // Stage B: degrees to Q30 radians
  logic [APW-1:0]       az_prod;
  logic [APW-1:0]       el_prod;
  logic signed [ZW-1:0] z_az_nxt;
  logic signed [ZW-1:0] el_zmag;
  logic signed [ZW-1:0] z_el_nxt;

  always_comb begin
    az_prod  = APW'(a_az_r) * APW'(RAD_PER_DEG_Q48) + (APW'(1) << (ANG_SHIFT - 1));
    el_prod  = APW'(a_el_r) * APW'(RAD_PER_DEG_Q48) + (APW'(1) << (ANG_SHIFT - 1));
    z_az_nxt = $signed({3'b000, az_prod[APW-2:ANG_SHIFT]});
    el_zmag  = $signed({3'b000, el_prod[APW-2:ANG_SHIFT]});
    z_el_nxt = a_elneg_r ? -el_zmag : el_zmag;
  end

  // Rotation stages, azimuth and elevation side by side
  wire signed [ZW-1:0] atan_w [0:N-1];
  for (genvar k = 0; k < N; k++) begin : g_atan
    assign atan_w[k] = ZW'(atan_q30(k));
  end

  logic signed [XW-1:0] rot_ax_r [0:N];
  logic signed [XW-1:0] rot_ay_r [0:N];
  logic signed [ZW-1:0] rot_az_r [0:N];
  logic signed [XW-1:0] rot_ex_r [0:N];
  logic signed [XW-1:0] rot_ey_r [0:N];
  logic signed [ZW-1:0] rot_ez_r [0:N];
  quad_t                q_r      [0:N];
  logic [23:0]          rad_r    [0:N];

  // Stage R: sin/cos rounding and quadrant mapping
  logic signed [CW-1:0] c0, s0;
  logic signed [CW-1:0] r_ca_nxt, r_sa_nxt, r_ce_nxt, r_se_nxt;
  logic signed [CW-1:0] r_ca_r, r_sa_r, r_ce_r, r_se_r;
  logic [23:0]          r_rad_r;

  always_comb begin
    c0 = to_unit(rot_ax_r[N]);
    s0 = to_unit(rot_ay_r[N]);
    unique case (q_r[N])
      QUAD_I: begin
        r_ca_nxt = c0;
        r_sa_nxt = s0;
      end
      QUAD_II: begin
        r_ca_nxt = -s0;
        r_sa_nxt = c0;
      end
      QUAD_III: begin
        r_ca_nxt = -c0;
        r_sa_nxt = -s0;
      end
      QUAD_IV: begin
        r_ca_nxt = s0;
        r_sa_nxt = -c0;
      end
    endcase
    r_ce_nxt = to_unit(rot_ex_r[N]);
    r_se_nxt = to_unit(rot_ey_r[N]);
  end

  // Stage M1: radius times elevation terms
  logic signed [24:0]    rad_s;
  logic signed [RW-1:0]  pt, pz, tr, zr;
  logic signed [TW-1:0]  m_t_nxt, m_t_r;
  logic signed [OW-1:0]  m_z_nxt, m_z_r;
  logic signed [CW-1:0]  m_ca_r, m_sa_r;

  always_comb begin
    rad_s   = $signed({1'b0, r_rad_r});
    pt      = rad_s * r_ce_r;
    pz      = rad_s * r_se_r;
    tr      = rnd_prod(pt);
    zr      = rnd_prod(pz);
    m_t_nxt = tr[TW-1:0];
    m_z_nxt = sat_out(zr);
  end

  // Stage M2: horizontal projection times azimuth terms
  logic signed [RW-1:0] px, py, xr, yr;
  logic signed [OW-1:0] x_nxt, y_nxt;
  logic signed [OW-1:0] x_r, y_r, z_r;

  always_comb begin
    px    = m_t_r * m_ca_r;
    py    = m_t_r * m_sa_r;
    xr    = rnd_prod(px);
    yr    = rnd_prod(py);
    x_nxt = sat_out(xr);
    y_nxt = sat_out(yr);
  end

  assign out_x_coord = x_r;
  assign out_y_coord = y_r;
  assign out_z_coord = z_r;

  // Payload registers
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      a_q_r     <= a_q_nxt;
      a_az_r    <= a_az_nxt;
      a_el_r    <= a_el_nxt;
      a_elneg_r <= a_elneg_nxt;
      a_rad_r   <= a_rad_nxt;
    end
    if (adv[1]) begin
      rot_ax_r[0] <= GAIN;
      rot_ay_r[0] <= '0;
      rot_az_r[0] <= z_az_nxt;
      rot_ex_r[0] <= GAIN;
      rot_ey_r[0] <= '0;
      rot_ez_r[0] <= z_el_nxt;
      q_r[0]      <= a_q_r;
      rad_r[0]    <= a_rad_r;
    end
    for (int m = 0; m < N; m++) begin
      if (adv[m+2]) begin
        // azimuth rotation
        if (!rot_az_r[m][ZW-1]) begin
          rot_ax_r[m+1] <= rot_ax_r[m] - (rot_ay_r[m] >>> m);
          rot_ay_r[m+1] <= rot_ay_r[m] + (rot_ax_r[m] >>> m);
          rot_az_r[m+1] <= rot_az_r[m] - atan_w[m];
        end else begin
          rot_ax_r[m+1] <= rot_ax_r[m] + (rot_ay_r[m] >>> m);
          rot_ay_r[m+1] <= rot_ay_r[m] - (rot_ax_r[m] >>> m);
          rot_az_r[m+1] <= rot_az_r[m] + atan_w[m];
        end
        // elevation rotation
        if (!rot_ez_r[m][ZW-1]) begin
          rot_ex_r[m+1] <= rot_ex_r[m] - (rot_ey_r[m] >>> m);
          rot_ey_r[m+1] <= rot_ey_r[m] + (rot_ex_r[m] >>> m);
          rot_ez_r[m+1] <= rot_ez_r[m] - atan_w[m];
        end else begin
          rot_ex_r[m+1] <= rot_ex_r[m] + (rot_ey_r[m] >>> m);
          rot_ey_r[m+1] <= rot_ey_r[m] - (rot_ex_r[m] >>> m);
          rot_ez_r[m+1] <= rot_ez_r[m] + atan_w[m];
        end
        q_r[m+1]   <= q_r[m];
        rad_r[m+1] <= rad_r[m];
      end
    end
    if (adv[N+2]) begin
      r_ca_r  <= r_ca_nxt;
      r_sa_r  <= r_sa_nxt;
      r_ce_r  <= r_ce_nxt;
      r_se_r  <= r_se_nxt;
      r_rad_r <= rad_r[N];
    end
    if (adv[N+3]) begin
      m_t_r  <= m_t_nxt;
      m_z_r  <= m_z_nxt;
      m_ca_r <= r_ca_r;
      m_sa_r <= r_sa_r;
    end
    if (adv[N+4]) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= m_z_r;
    end
  end

  // Checks
  logic in_acc, out_acc;
  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // requests in flight change only by what enters and leaves
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> ($countones(v_r) ==
      $past($countones(v_r)) + int'($past(in_acc)) - int'($past(out_acc))))
    else $error("pipeline request count mismatch");

  // the input waits only when the output side does
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled with output free");

  // mapped sine and cosine stay within one
  a_unit: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[N+2] |-> (r_ca_r <= UNIT && r_ca_r >= -UNIT && r_sa_r <= UNIT &&
                  r_sa_r >= -UNIT && r_ce_r <= UNIT && r_ce_r >= -UNIT &&
                  r_se_r <= UNIT && r_se_r >= -UNIT))
    else $error("sine or cosine out of range");

endmodule
